// File: sv/bankers_safety_allocator_assert.svh
// Assertion macros for the allocator.
// Each macro names a concurrent assertion that reports through $error.
`ifndef BANKERS_SAFETY_ALLOCATOR_ASSERT_SVH
`define BANKERS_SAFETY_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Checked while out of reset.
`define BSA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Checked at every edge, reset included.
`define BSA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BSA_ASSERT(lbl, clk, rstn, prop, msg)
`define BSA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: sv/bsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bsa_pkg;

  // Table geometry.
  localparam int PROCESSES  = 8;
  localparam int RESOURCES  = 3;
  localparam int UNIT_WIDTH = 8;

  // Fixed widths of the item fields.
  localparam int FIELD_W      = 8;
  localparam int PROC_FIELD_W = 3;

  localparam int ROW_W  = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int CMP_W  = (UNIT_WIDTH > FIELD_W) ? UNIT_WIDTH : FIELD_W;
  localparam int WORK_W = UNIT_WIDTH + $clog2(PROCESSES + 1);

  localparam logic [CMP_W-1:0] UNIT_MAX = CMP_W'((33'd1 << UNIT_WIDTH) - 33'd1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(PROCESSES - 1);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_SET   = 2'd1,
    OP_REQ   = 2'd2,
    OP_QUERY = 2'd3
  } bsa_op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NEED     = 3'd1,
    ST_AVAIL    = 3'd2,
    ST_UNSAFE   = 3'd3,
    ST_BAD_LOAD = 3'd4
  } bsa_status_e;

  typedef struct packed {
    logic [1:0]              operation;
    logic [PROC_FIELD_W-1:0] process;
    logic [FIELD_W-1:0]      units_0;
    logic [FIELD_W-1:0]      units_1;
    logic [FIELD_W-1:0]      units_2;
    logic [FIELD_W-1:0]      held_0;
    logic [FIELD_W-1:0]      held_1;
    logic [FIELD_W-1:0]      held_2;
  } bsa_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic       safe;
  } bsa_out_t;

  typedef logic [RESOURCES-1:0][UNIT_WIDTH-1:0] bsa_row_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic scan_init;
    logic scan_step;
    logic rollback;
  } bsa_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_end;
    logic unsafe_grant;
  } bsa_stat_t;

  // Picks one resource's units or held field, zero-extended for compares.
  function automatic logic [CMP_W-1:0] unit_field(bsa_in_t it, int idx, logic held);
    logic [FIELD_W-1:0] v;
    case (idx)
      0:       v = held ? it.held_0 : it.units_0;
      1:       v = held ? it.held_1 : it.units_1;
      2:       v = held ? it.held_2 : it.units_2;
      default: v = '0;
    endcase
    return CMP_W'(v);
  endfunction

endpackage
`default_nettype wire

// File: sv/bsa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "bankers_safety_allocator_assert.svh"
module bsa_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire bsa_pkg::bsa_stat_t stat_i,
  output bsa_pkg::bsa_cmd_t       cmd_o,
  output logic                    busy_o,
  output logic                    valid_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_SINIT = 6'b000100,
    S_SCAN  = 6'b001000,
    S_ROLLB = 6'b010000,
    S_RESP  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Sequence: execute the operation, run the safety scan, undo an unsafe
  // grant, then present the result for one cycle.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_SINIT;
      end
      S_SINIT: begin
        cmd_o.scan_init = 1'b1;
        state_d         = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_end) begin
          state_d = stat_i.unsafe_grant ? S_ROLLB : S_RESP;
        end
      end
      S_ROLLB: begin
        cmd_o.rollback = 1'b1;
        state_d        = S_RESP;
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o  = (state_q != S_IDLE);
  assign valid_o = (state_q == S_RESP);

  // The result strobe lasts one cycle, and an accepted item makes the block busy.
  `BSA_ASSERT(a_strobe_single, clk_i, rst_ni, valid_o |=> !valid_o, "strobe held over two cycles")
  `BSA_ASSERT(a_accept_busy, clk_i, rst_ni, (start_i && !busy_o) |=> busy_o, "item taken but not busy")
  `BSA_ASSERT(a_rollb_resp, clk_i, rst_ni, cmd_o.rollback |=> valid_o, "rollback not followed by result")

endmodule
`default_nettype wire

// File: sv/bsa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
`include "bankers_safety_allocator_assert.svh"
module bsa_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bsa_pkg::bsa_in_t  item_i,
  input  wire bsa_pkg::bsa_cmd_t cmd_i,
  output bsa_pkg::bsa_stat_t     stat_o,
  output bsa_pkg::bsa_out_t      result_o
);

  localparam int R  = bsa_pkg::RESOURCES;
  localparam int UW = bsa_pkg::UNIT_WIDTH;
  localparam int CW = bsa_pkg::CMP_W;
  localparam int WW = bsa_pkg::WORK_W;
  localparam int RW = bsa_pkg::ROW_W;

  bsa_pkg::bsa_row_t claim_q [bsa_pkg::PROCESSES];
  bsa_pkg::bsa_row_t alloc_q [bsa_pkg::PROCESSES];
  logic [R-1:0][UW-1:0] avail_q;

  bsa_pkg::bsa_in_t item_q;
  logic [2:0]       status_q;
  logic             safe_q;
  logic             granted_q;

  logic [R-1:0][WW-1:0]         work_q;
  logic [bsa_pkg::PROCESSES-1:0] done_q;
  logic                          progress_q;
  logic [RW-1:0]                 ptr_q;

  logic                 proc_ok;
  logic [RW-1:0]        pidx;
  logic [RW-1:0]        row_addr;
  bsa_pkg::bsa_row_t    rd_claim, rd_alloc;
  logic [R-1:0][UW-1:0] rd_need;
  logic [R-1:0][CW-1:0] units_c, held_c;
  logic                 bad_load, need_exc, avail_exc, grant;
  logic                 fits, hit;
  logic [bsa_pkg::PROCESSES-1:0] done_next;
  logic                 progress_next, all_done_next, last_row, scan_end;

  assign proc_ok  = (int'(item_q.process) < bsa_pkg::PROCESSES);
  assign pidx     = RW'(item_q.process);
  assign row_addr = cmd_i.scan_step ? ptr_q : pidx;

  // One row read port shared by the operation and the scan.
  always_comb begin
    rd_claim = '0;
    rd_alloc = '0;
    if (int'(row_addr) < bsa_pkg::PROCESSES) begin
      rd_claim = claim_q[row_addr];
      rd_alloc = alloc_q[row_addr];
    end
    for (int r = 0; r < R; r++) begin
      rd_need[r] = (rd_claim[r] >= rd_alloc[r]) ? (rd_claim[r] - rd_alloc[r]) : '0;
    end
  end

  // Operation checks on the captured item.
  always_comb begin
    bad_load  = !proc_ok;
    need_exc  = !proc_ok;
    avail_exc = 1'b0;
    for (int r = 0; r < R; r++) begin
      units_c[r] = bsa_pkg::unit_field(item_q, r, 1'b0);
      held_c[r]  = bsa_pkg::unit_field(item_q, r, 1'b1);
      if (units_c[r] > bsa_pkg::UNIT_MAX || held_c[r] > bsa_pkg::UNIT_MAX ||
          held_c[r] > units_c[r]) begin
        bad_load = 1'b1;
      end
      if (units_c[r] > CW'(rd_need[r])) begin
        need_exc = 1'b1;
      end
      if (units_c[r] > CW'(avail_q[r])) begin
        avail_exc = 1'b1;
      end
    end
    grant = !need_exc && !avail_exc;
  end

  // Scan step: a pending row whose need fits the work vector finishes.
  always_comb begin
    fits = 1'b1;
    for (int r = 0; r < R; r++) begin
      if (WW'(rd_need[r]) > work_q[r]) begin
        fits = 1'b0;
      end
    end
    hit       = fits && !done_q[ptr_q];
    done_next = done_q;
    if (hit) begin
      done_next[ptr_q] = 1'b1;
    end
    progress_next = progress_q || hit;
    all_done_next = &done_next;
    last_row      = (ptr_q == bsa_pkg::LAST_ROW);
    scan_end      = last_row && (!progress_next || all_done_next);
  end

  assign stat_o.scan_end     = cmd_i.scan_step && scan_end;
  assign stat_o.unsafe_grant = granted_q && !all_done_next;

  // Tables and available units.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < bsa_pkg::PROCESSES; p++) begin
        claim_q[p] <= '0;
        alloc_q[p] <= '0;
      end
      avail_q   <= '0;
      granted_q <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        granted_q <= 1'b0;
        case (bsa_pkg::bsa_op_e'(item_q.operation))
          bsa_pkg::OP_LOAD: begin
            if (!bad_load) begin
              for (int r = 0; r < R; r++) begin
                claim_q[pidx][r] <= UW'(units_c[r]);
                alloc_q[pidx][r] <= UW'(held_c[r]);
              end
            end
          end
          bsa_pkg::OP_SET: begin
            for (int r = 0; r < R; r++) begin
              avail_q[r] <= (units_c[r] > bsa_pkg::UNIT_MAX) ? UW'(bsa_pkg::UNIT_MAX)
                                                              : UW'(units_c[r]);
            end
          end
          bsa_pkg::OP_REQ: begin
            granted_q <= grant;
            if (grant) begin
              for (int r = 0; r < R; r++) begin
                avail_q[r]       <= avail_q[r] - UW'(units_c[r]);
                alloc_q[pidx][r] <= rd_alloc[r] + UW'(units_c[r]);
              end
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd_i.rollback) begin
        for (int r = 0; r < R; r++) begin
          avail_q[r]       <= avail_q[r] + UW'(units_c[r]);
          alloc_q[pidx][r] <= rd_alloc[r] - UW'(units_c[r]);
        end
      end
    end
  end

  // Item capture, result fields and the scan registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    if (cmd_i.exec) begin
      case (bsa_pkg::bsa_op_e'(item_q.operation))
        bsa_pkg::OP_LOAD: status_q <= bad_load ? bsa_pkg::ST_BAD_LOAD : bsa_pkg::ST_OK;
        bsa_pkg::OP_REQ: begin
          if (need_exc) begin
            status_q <= bsa_pkg::ST_NEED;
          end else if (avail_exc) begin
            status_q <= bsa_pkg::ST_AVAIL;
          end else begin
            status_q <= bsa_pkg::ST_OK;
          end
        end
        default: status_q <= bsa_pkg::ST_OK;
      endcase
    end
    if (cmd_i.rollback) begin
      status_q <= bsa_pkg::ST_UNSAFE;
    end
    if (cmd_i.scan_init) begin
      for (int r = 0; r < R; r++) begin
        work_q[r] <= WW'(avail_q[r]);
      end
      done_q     <= '0;
      progress_q <= 1'b0;
      ptr_q      <= '0;
    end
    if (cmd_i.scan_step) begin
      if (hit) begin
        for (int r = 0; r < R; r++) begin
          work_q[r] <= work_q[r] + WW'(rd_alloc[r]);
        end
      end
      done_q <= done_next;
      // A pass ends at the last row; another starts only if it made progress.
      if (last_row) begin
        ptr_q      <= '0;
        progress_q <= 1'b0;
      end else begin
        ptr_q      <= ptr_q + RW'(1);
        progress_q <= progress_next;
      end
      if (scan_end) begin
        safe_q <= all_done_next;
      end
    end
  end

  assign result_o.status = status_q;
  assign result_o.safe   = safe_q;

  // A rollback undoes only a tentative grant and yields the unsafe status.
  `BSA_ASSERT(a_rollb_granted, clk_i, rst_ni,
              cmd_i.rollback |-> (granted_q && !safe_q), "rollback without unsafe grant")
  `BSA_ASSERT(a_rollb_status, clk_i, rst_ni,
              cmd_i.rollback |=> (status_q == bsa_pkg::ST_UNSAFE), "rollback status lost")
  `BSA_ASSERT(a_ptr_range, clk_i, rst_ni,
              cmd_i.scan_step |-> (ptr_q <= bsa_pkg::LAST_ROW), "scan pointer out of range")

endmodule
`default_nettype wire

// File: sv/bankers_safety_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// Deadlock-avoidance allocator with claim and allocation tables.
// Input channel: item_i is taken at a rising edge with start_i high and busy_o
// low. The item loads a process row, sets the available units, requests units
// for a process, or queries safety.
// Output channel: result_o carries status and safe, marked by valid_o for
// exactly one cycle; the receiver cannot stall it and must take it then.
// Sequence: the operation executes, the safety scan is seeded, then the scan
// visits one process row per cycle for one to PROCESSES passes, an unsafe
// grant is undone, and valid_o follows. Most of the time goes to the scan
// loop over the single row read port.
// busy_o stays high until the strobe cycle ends; the next item may be taken
// at the edge after it.
// Reset clears the tables and the available units to zero and idles the block.
module bankers_safety_allocator (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire bsa_pkg::bsa_in_t item_i,
  output logic                  busy_o,
  output logic                  valid_o,
  output bsa_pkg::bsa_out_t     result_o
);

  bsa_pkg::bsa_cmd_t  cmd;
  bsa_pkg::bsa_stat_t stat;

  // Sequencer.
  bsa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .valid_o (valid_o)
  );

  // Tables, checks and safety scan.
  bsa_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .result_o (result_o)
  );

endmodule
`default_nettype wire
